FILE: rtl/core/hidp_pkg.sv
// ----------------------------------------------------------------------------
// hidp_pkg
// Shared types and codes for the HID descriptor item parser.
// ----------------------------------------------------------------------------
package hidp_pkg;

	localparam int MAX_USAGES_DEF = 32;

	// item tag/type codes (key & 0xFC)
	localparam logic [7:0] TAG_MASK    = 8'hFC;
	localparam logic [7:0] TAG_PAGE    = 8'h04;
	localparam logic [7:0] TAG_USAGE   = 8'h08;
	localparam logic [7:0] TAG_RSIZE   = 8'h74;
	localparam logic [7:0] TAG_RCOUNT  = 8'h94;
	localparam logic [7:0] TAG_INPUT   = 8'h80;
	localparam logic [7:0] TAG_OUTPUT  = 8'h90;
	localparam logic [7:0] TAG_FEATURE = 8'hB0;
	localparam logic [7:0] TAG_RID     = 8'h84;
	localparam logic [7:0] TAG_UMIN    = 8'h18;
	localparam logic [7:0] TAG_UMAX    = 8'h28;
	localparam logic [7:0] TAG_LMAX    = 8'h24;

	// result kinds
	localparam logic [1:0] KIND_FIELD   = 2'd0;
	localparam logic [1:0] KIND_USAGE   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] word_a;
		logic [31:0] word_b;
		logic [32:0] word_c;
		logic        var_flag;
		logic [15:0] page;
		logic [15:0] usage_value;
		logic [5:0]  usage_count;
		logic [8:0]  distinct_ids;
		logic        usages_truncated;
		logic        last;
	} rec_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic mul;
		logic acc;
		logic push_field;
		logic push_usage;
		logic fill;
		logic push_sum;
	} cmd_t;

	typedef struct packed {
		logic item_done;
		logic end_in;
		logic end_q;
		logic is_io;
		logic is_input;
		logic is_range;
		logic out_free;
		logic has_usages;
		logic usage_last;
		logic fill_busy;
	} status_t;

endpackage

FILE: rtl/core/hidp_if.sv
// ----------------------------------------------------------------------------
// hidp_desc_if / hidp_rec_if
// Valid/ready channels for descriptor bytes in and parse records out.
// ----------------------------------------------------------------------------
interface hidp_desc_if;
	logic       valid;
	logic       ready;
	logic [7:0] desc_byte;
	logic       end_of_desc;

	modport source (output valid, output desc_byte, output end_of_desc, input ready);
	modport sink (input valid, input desc_byte, input end_of_desc, output ready);
endinterface

interface hidp_rec_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] word_a;
	logic [31:0] word_b;
	logic [32:0] word_c;
	logic        var_flag;
	logic [15:0] page;
	logic [15:0] usage_value;
	logic [5:0]  usage_count;
	logic [8:0]  distinct_ids;
	logic        usages_truncated;
	logic        last;

	modport source (output valid, output kind, output word_a, output word_b, output word_c,
		output var_flag, output page, output usage_value, output usage_count,
		output distinct_ids, output usages_truncated, output last, input ready);
	modport sink (input valid, input kind, input word_a, input word_b, input word_c,
		input var_flag, input page, input usage_value, input usage_count,
		input distinct_ids, input usages_truncated, input last, output ready);
endinterface

FILE: rtl/core/hidp_ctrl.sv
// ----------------------------------------------------------------------------
// hidp_ctrl
// Sequencer: byte accept, item execute, totals, record emission, summary.
// ----------------------------------------------------------------------------
module hidp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  hidp_pkg::status_t st,
	output hidp_pkg::cmd_t    cmd
);
	import hidp_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_ACC   = 3'd3;
	localparam logic [2:0] S_FIELD = 3'd4;
	localparam logic [2:0] S_USAGE = 3'd5;
	localparam logic [2:0] S_FILL  = 3'd6;
	localparam logic [2:0] S_SUM   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [2:0] post;

	assign post = st.end_q ? S_SUM : S_IDLE;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.item_done) state_d = S_EXEC;
					else if (st.end_in) state_d = S_SUM;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.is_io) state_d = S_MUL;
				else if (st.is_range) state_d = S_FILL;
				else state_d = post;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = st.is_input ? S_FIELD : post;
			end
			S_FIELD: begin
				if (st.out_free) begin
					cmd.push_field = 1'b1;
					state_d = st.has_usages ? S_USAGE : post;
				end
			end
			S_USAGE: begin
				if (st.out_free) begin
					cmd.push_usage = 1'b1;
					if (st.usage_last) state_d = post;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (!st.fill_busy) state_d = post;
			end
			S_SUM: begin
				if (st.out_free) begin
					cmd.push_sum = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: rtl/core/hidp_dp.sv
// ----------------------------------------------------------------------------
// hidp_dp
// Datapath: byte framing, parser state, usage store, report-id map, totals
// and the output record register.
// ----------------------------------------------------------------------------
module hidp_dp #(
	parameter int MAX_USAGES = hidp_pkg::MAX_USAGES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        desc_byte,
	input  logic              end_of_desc,
	input  hidp_pkg::cmd_t    cmd,
	output hidp_pkg::status_t st,
	output logic              rec_valid,
	input  logic              rec_ready,
	output hidp_pkg::rec_t    rec
);
	import hidp_pkg::*;

	localparam int AW = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
	localparam int FW = $clog2(MAX_USAGES + 1);
	localparam logic [FW-1:0] MAX_F = FW'(MAX_USAGES);

	localparam logic [1:0] PH_KEY   = 2'd0;
	localparam logic [1:0] PH_LLEN  = 2'd1;
	localparam logic [1:0] PH_LSKIP = 2'd2;
	localparam logic [1:0] PH_DATA  = 2'd3;

	// framing
	logic [1:0]  phase_q;
	logic [7:0]  key_q;
	logic [8:0]  left_q;
	logic [31:0] word_q;
	logic [2:0]  pos_q;
	logic [2:0]  len_q;
	logic        end_q;

	// parser state
	logic [15:0] page_q, first_page_q, first_usage_q;
	logic [31:0] size_q, count_q, rstart_q, ltop_q;
	logic [31:0] in_tot_q, out_tot_q, feat_tot_q;
	logic [FW-1:0] fill_q;
	logic        ovf_q;
	logic [255:0] id_map_q;
	logic [8:0]  ids_q;

	// range fill / emission
	logic [FW-1:0] fleft_q;
	logic [15:0]   fval_q;
	logic [AW-1:0] eidx_q, rd_addr;
	logic [15:0]   rdata_q;
	logic [31:0]   prod_s1;
	logic [15:0]   mem [MAX_USAGES];

	logic        out_valid_q;
	rec_t        rec_q;

	// byte decode
	logic [1:0]  code;
	logic        long_key;
	logic [8:0]  left_dec;
	logic        item_done;
	logic [7:0]  tag;
	logic [31:0] val;
	logic [15:0] u_id, u_pg;
	logic [31:0] span, room;
	logic        push_req;
	logic [15:0] push_val;
	logic        mem_we;
	logic        out_free;
	logic        usage_last;
	logic [31:0] sum_a, sum_b, sum_c;

	assign code     = desc_byte[1:0];
	assign long_key = (desc_byte[7:4] == 4'hF) && !end_of_desc;
	assign left_dec = left_q - {8'd0, (left_q != 9'd0)};

	always_comb begin
		item_done = 1'b0;
		case (phase_q)
			PH_KEY:  item_done = !long_key && ((code == 2'd0) || end_of_desc);
			PH_DATA: item_done = (left_dec == 9'd0) || end_of_desc;
			default: item_done = 1'b0;
		endcase
	end

	assign tag = key_q & TAG_MASK;
	assign val = ({1'b0, pos_q} >= {1'b0, len_q}) ? word_q : 32'd0;
	assign u_pg = (pos_q >= 3'd4) ? word_q[31:16] : 16'd0;
	assign u_id = (len_q == 3'd4) ? ((pos_q >= 3'd2) ? word_q[15:0] : 16'd0) : val[15:0];
	assign span = val + 32'd1 - rstart_q;
	assign room = 32'(MAX_USAGES) - 32'(fill_q);

	always_comb begin
		push_req = 1'b0;
		push_val = fval_q;
		if (cmd.exec && (tag == TAG_USAGE) && (first_usage_q != 16'd0)) begin
			push_req = 1'b1;
			push_val = u_id;
		end else if (cmd.fill && (fleft_q != '0)) begin
			push_req = 1'b1;
		end
	end
	assign mem_we = push_req && (fill_q < MAX_F);

	assign out_free   = !out_valid_q || rec_ready;
	assign usage_last = (FW'(eidx_q) + FW'(1)) == fill_q;

	assign sum_a = ((in_tot_q + 32'd7) >> 3) + 32'd1;
	assign sum_b = ((out_tot_q + 32'd7) >> 3) + 32'd1;
	assign sum_c = ((feat_tot_q + 32'd7) >> 3) + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_KEY; key_q <= '0; left_q <= '0; word_q <= '0;
			pos_q <= '0; len_q <= '0; end_q <= 1'b0;
			page_q <= '0; first_page_q <= '0; first_usage_q <= '0;
			size_q <= '0; count_q <= '0; rstart_q <= '0; ltop_q <= '0;
			in_tot_q <= '0; out_tot_q <= '0; feat_tot_q <= '0;
			fill_q <= '0; ovf_q <= 1'b0; id_map_q <= '0; ids_q <= '0;
			fleft_q <= '0; fval_q <= '0;
		end else if (cmd.push_sum) begin
			// end of descriptor: back to reset state
			phase_q <= PH_KEY; key_q <= '0; left_q <= '0; word_q <= '0;
			pos_q <= '0; len_q <= '0; end_q <= 1'b0;
			page_q <= '0; first_page_q <= '0; first_usage_q <= '0;
			size_q <= '0; count_q <= '0; rstart_q <= '0; ltop_q <= '0;
			in_tot_q <= '0; out_tot_q <= '0; feat_tot_q <= '0;
			fill_q <= '0; ovf_q <= 1'b0; id_map_q <= '0; ids_q <= '0;
			fleft_q <= '0; fval_q <= '0;
		end else begin
			if (cmd.accept) begin
				end_q <= end_of_desc;
				case (phase_q)
					PH_KEY: begin
						key_q  <= desc_byte;
						word_q <= '0;
						pos_q  <= '0;
						if (long_key) begin
							phase_q <= PH_LLEN;
						end else begin
							len_q <= (code == 2'd3) ? 3'd4 : {1'b0, code};
							if ((code == 2'd0) || end_of_desc) begin
								phase_q <= PH_KEY;
							end else begin
								left_q  <= (code == 2'd3) ? 9'd4 : {7'd0, code};
								phase_q <= PH_DATA;
							end
						end
					end
					PH_LLEN: begin
						left_q  <= {1'b0, desc_byte} + 9'd1;
						phase_q <= PH_LSKIP;
					end
					PH_LSKIP: begin
						left_q <= left_dec;
						if (left_dec == 9'd0) phase_q <= PH_KEY;
					end
					PH_DATA: begin
						if (pos_q < 3'd4)
							word_q <= word_q | ({24'd0, desc_byte} << {pos_q[1:0], 3'b000});
						pos_q  <= pos_q + 3'd1;
						left_q <= left_dec;
						if (item_done) phase_q <= PH_KEY;
					end
					default: phase_q <= PH_KEY;
				endcase
			end

			if (cmd.exec) begin
				case (tag)
					TAG_PAGE: begin
						page_q <= val[15:0];
						if (first_page_q == 16'd0) first_page_q <= val[15:0];
					end
					TAG_USAGE: begin
						if (len_q == 3'd4) begin
							page_q <= u_pg;
							if (first_page_q == 16'd0) first_page_q <= u_pg;
						end
						if (first_usage_q == 16'd0) first_usage_q <= u_id;
					end
					TAG_RSIZE:  size_q <= val;
					TAG_RCOUNT: count_q <= val;
					TAG_LMAX:   ltop_q <= val;
					TAG_UMIN:   rstart_q <= val;
					TAG_INPUT: begin
						if (!val[1]) begin
							fill_q <= '0;
							ovf_q  <= 1'b0;
						end
					end
					TAG_OUTPUT, TAG_FEATURE: begin
						fill_q <= '0;
						ovf_q  <= 1'b0;
					end
					TAG_RID: begin
						if (!id_map_q[val[7:0]]) begin
							id_map_q[val[7:0]] <= 1'b1;
							ids_q <= ids_q + 9'd1;
						end
					end
					TAG_UMAX: begin
						fval_q <= rstart_q[15:0];
						if (span == 32'd0) begin
							fleft_q <= '0;
						end else begin
							fleft_q <= (span < room) ? FW'(span) : FW'(room);
							if (span > room) ovf_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end

			if (cmd.fill && (fleft_q != '0)) begin
				fleft_q <= fleft_q - FW'(1);
				fval_q  <= fval_q + 16'd1;
			end

			if (push_req) begin
				if (fill_q < MAX_F) fill_q <= fill_q + FW'(1);
				else ovf_q <= 1'b1;
			end

			if (cmd.acc) begin
				case (tag)
					TAG_INPUT:   in_tot_q <= in_tot_q + prod_s1;
					TAG_OUTPUT:  out_tot_q <= out_tot_q + prod_s1;
					TAG_FEATURE: feat_tot_q <= feat_tot_q + prod_s1;
					default: ;
				endcase
			end

			// list clears once the field's usages are out
			if ((cmd.push_field && (fill_q == '0)) || (cmd.push_usage && usage_last)) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) prod_s1 <= size_q * count_q;
	end

	// usage store
	always_comb begin
		if (cmd.push_field) rd_addr = '0;
		else if (cmd.push_usage) rd_addr = eidx_q + AW'(1);
		else rd_addr = eidx_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[fill_q[AW-1:0]] <= push_val;
		rdata_q <= mem[rd_addr];
		eidx_q  <= rd_addr;
	end

	// output record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.push_field || cmd.push_usage || cmd.push_sum) out_valid_q <= 1'b1;
		else if (rec_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push_field) begin
			rec_q <= '0;
			rec_q.kind <= KIND_FIELD;
			rec_q.word_a <= size_q;
			rec_q.word_b <= count_q;
			rec_q.word_c <= {1'b0, ltop_q} + {32'd0, val[6]};
			rec_q.var_flag <= val[1];
			rec_q.page <= page_q;
			rec_q.usage_count <= 6'(fill_q);
			rec_q.usages_truncated <= ovf_q;
			rec_q.last <= !end_q && (fill_q == '0);
		end else if (cmd.push_usage) begin
			rec_q <= '0;
			rec_q.kind <= KIND_USAGE;
			rec_q.usage_value <= rdata_q;
			rec_q.last <= !end_q && usage_last;
		end else if (cmd.push_sum) begin
			rec_q <= '0;
			rec_q.kind <= KIND_SUMMARY;
			rec_q.word_a <= sum_a;
			rec_q.word_b <= sum_b;
			rec_q.word_c <= {1'b0, sum_c};
			rec_q.page <= first_page_q;
			rec_q.usage_value <= first_usage_q;
			rec_q.distinct_ids <= ids_q;
			rec_q.last <= 1'b1;
		end
	end

	assign rec_valid = out_valid_q;
	assign rec = rec_q;

	always_comb begin
		st.item_done  = item_done;
		st.end_in     = end_of_desc;
		st.end_q      = end_q;
		st.is_io      = (tag == TAG_INPUT) || (tag == TAG_OUTPUT) || (tag == TAG_FEATURE);
		st.is_input   = (tag == TAG_INPUT);
		st.is_range   = (tag == TAG_UMAX);
		st.out_free   = out_free;
		st.has_usages = (fill_q != '0);
		st.usage_last = usage_last;
		st.fill_busy  = (fleft_q != '0);
	end

endmodule

FILE: rtl/core/hid_descriptor_item_parser_core.sv
// ----------------------------------------------------------------------------
// hid_descriptor_item_parser_core
// HID report descriptor parser: bytes in, field/usage/summary records out.
// ----------------------------------------------------------------------------
// One descriptor byte is taken per handshake. A byte that completes an item
// is accepted and then executed; Input, Output and Feature then run the
// size*count multiply and the total update, and a Usage Maximum runs the
// range fill, which adds its usages one at a time (the store has one write
// port). Records are emitted after that (a field record on Input, then one
// usage record per stored usage read from the store, then the summary on
// the last byte), each record waiting while the output register is held.
// New bytes are refused while a sequence runs; a waiting output record does
// not block bytes that produce no record. The end-of-descriptor summary
// clears all parser state, the report-id map included, in the same cycle
// it is loaded.
// ----------------------------------------------------------------------------
module hid_descriptor_item_parser_core #(
	parameter int MAX_USAGES = hidp_pkg::MAX_USAGES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	hidp_desc_if.sink   desc,
	hidp_rec_if.source  rec
);
	import hidp_pkg::*;

	cmd_t    cmd;
	status_t st;
	rec_t    rec_d;
	logic    rec_valid;

	// sequencer
	hidp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (desc.valid),
		.in_ready (desc.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// parser state, usage store and output register
	hidp_dp #(.MAX_USAGES(MAX_USAGES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.desc_byte   (desc.desc_byte),
		.end_of_desc (desc.end_of_desc),
		.cmd         (cmd),
		.st          (st),
		.rec_valid   (rec_valid),
		.rec_ready   (rec.ready),
		.rec         (rec_d)
	);

	assign rec.valid            = rec_valid;
	assign rec.kind             = rec_d.kind;
	assign rec.word_a           = rec_d.word_a;
	assign rec.word_b           = rec_d.word_b;
	assign rec.word_c           = rec_d.word_c;
	assign rec.var_flag         = rec_d.var_flag;
	assign rec.page             = rec_d.page;
	assign rec.usage_value      = rec_d.usage_value;
	assign rec.usage_count      = rec_d.usage_count;
	assign rec.distinct_ids     = rec_d.distinct_ids;
	assign rec.usages_truncated = rec_d.usages_truncated;
	assign rec.last             = rec_d.last;

endmodule

FILE: rtl/core/hidp_checker.sv
// ----------------------------------------------------------------------------
// hidp_checker
// Port-level checks on the parser's record stream.
// ----------------------------------------------------------------------------
module hidp_checker #(
	parameter int MAX_USAGES = hidp_pkg::MAX_USAGES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  kind,
	input logic [5:0]  usage_count,
	input logic        var_flag,
	input logic        usages_truncated,
	input logic        last
);
	import hidp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(kind) && $stable(last))
		else $error("record dropped or changed under stall");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (kind == KIND_FIELD) || (kind == KIND_USAGE) || (kind == KIND_SUMMARY))
		else $error("bad record kind");

	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_SUMMARY) |-> last)
		else $error("summary not marked last");

	a_field: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_FIELD) |->
			(usage_count <= 6'(MAX_USAGES)) &&
			(var_flag || ((usage_count == 6'd0) && !usages_truncated)))
		else $error("field record usage count inconsistent");

endmodule

bind hid_descriptor_item_parser_core hidp_checker #(.MAX_USAGES(MAX_USAGES)) u_hidp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.valid            (rec.valid),
	.ready            (rec.ready),
	.kind             (rec.kind),
	.usage_count      (rec.usage_count),
	.var_flag         (rec.var_flag),
	.usages_truncated (rec.usages_truncated),
	.last             (rec.last)
);

FILE: sim/hidp_parser_checker.sv
// ----------------------------------------------------------------------------
// hidp_parser_checker
// Watches the descriptor byte and record channels of the HID descriptor item
// parser, predicts the records each accepted byte produces and compares every
// accepted record against the oldest prediction.
// ----------------------------------------------------------------------------
module hidp_parser_checker (
	input  logic      clk,
	input  logic      arst_n,
	hidp_desc_if      desc,
	hidp_rec_if       rec,
	output int        fail_count,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import hidp_pkg::*;

	localparam int NUM_USAGES = MAX_USAGES_DEF;

	typedef enum logic [1:0] {ST_KEY, ST_LONG_LEN, ST_LONG_SKIP, ST_DATA} parse_st_e;

	parse_st_e   st;
	logic [7:0]  key;
	logic [31:0] left, word, pos, dlen;
	logic [15:0] cur_page, first_pg, first_use;
	logic [31:0] rsize, rcount, rmin, lmax, in_bits, out_bits, feat_bits;
	logic [15:0] ulist [NUM_USAGES];
	int          ufill;
	logic        ovf;
	logic        rid_map [256];

	rec_t rec_q [$];

	assign pending = rec_q.size();

	function automatic void clear_state();
		st = ST_KEY; key = '0; left = '0; word = '0; pos = '0; dlen = '0;
		cur_page = '0; first_pg = '0; first_use = '0;
		rsize = '0; rcount = '0; rmin = '0; lmax = '0;
		in_bits = '0; out_bits = '0; feat_bits = '0;
		ufill = 0; ovf = 1'b0;
		foreach (rid_map[i]) rid_map[i] = 1'b0;
	endfunction

	function automatic void add_usage(logic [15:0] u);
		if (ufill < NUM_USAGES) begin
			ulist[ufill] = u;
			ufill++;
		end else
			ovf = 1'b1;
	endfunction

	function automatic void post(rec_t r);
		rec_q.push_back(r);
	endfunction

	function automatic void run_item();
		logic [31:0] val, span, room, take;
		logic [15:0] id;
		logic        var_f;
		rec_t        r;
		val = (pos >= dlen) ? word : 32'd0;
		case (key & TAG_MASK)
			TAG_PAGE: begin
				cur_page = val[15:0];
				if (first_pg == 0) first_pg = cur_page;
			end
			TAG_USAGE: begin
				if (dlen == 4) begin
					cur_page = (pos >= 4) ? word[31:16] : 16'd0;
					if (first_pg == 0) first_pg = cur_page;
					id = (pos >= 2) ? word[15:0] : 16'd0;
				end else
					id = val[15:0];
				if (first_use == 0) first_use = id;
				else add_usage(id);
			end
			TAG_RSIZE:  rsize = val;
			TAG_RCOUNT: rcount = val;
			TAG_INPUT: begin
				var_f = val[1];
				in_bits += rsize * rcount;
				if (!var_f) begin
					ufill = 0; ovf = 1'b0;
				end
				r = '0;
				r.kind = KIND_FIELD;
				r.word_a = rsize;
				r.word_b = rcount;
				r.word_c = {1'b0, lmax} + val[6];
				r.var_flag = var_f;
				r.page = cur_page;
				r.usage_count = 6'(ufill);
				r.usages_truncated = ovf;
				post(r);
				for (int i = 0; i < ufill; i++) begin
					r = '0;
					r.kind = KIND_USAGE;
					r.usage_value = ulist[i];
					post(r);
				end
				ufill = 0; ovf = 1'b0;
			end
			TAG_OUTPUT: begin
				ufill = 0; ovf = 1'b0;
				out_bits += rsize * rcount;
			end
			TAG_FEATURE: begin
				ufill = 0; ovf = 1'b0;
				feat_bits += rsize * rcount;
			end
			TAG_RID:  rid_map[val[7:0]] = 1'b1;
			TAG_UMIN: rmin = val;
			TAG_UMAX: begin
				span = val + 32'd1 - rmin;
				room = NUM_USAGES - ufill;
				take = (span < room) ? span : room;
				if (span != 0) begin
					for (logic [31:0] i = 0; i < take; i++) add_usage(16'(rmin + i));
					if (span > room) ovf = 1'b1;
				end
			end
			TAG_LMAX: lmax = val;
			default: ;
		endcase
	endfunction

	// advance the parser by one byte, queueing the records it causes
	function automatic void take_byte(logic [7:0] b, logic eod);
		int   first_idx;
		int   ids;
		rec_t r;
		first_idx = rec_q.size();
		case (st)
			ST_KEY: begin
				key = b; word = '0; pos = '0;
				if (b[7:4] == 4'hF && !eod)
					st = ST_LONG_LEN;
				else begin
					dlen = (b[1:0] == 2'd3) ? 32'd4 : 32'(b[1:0]);
					if (dlen == 0 || eod)
						run_item();
					else begin
						left = dlen;
						st = ST_DATA;
					end
				end
			end
			ST_LONG_LEN: begin
				left = 32'(b) + 1;
				st = ST_LONG_SKIP;
			end
			ST_LONG_SKIP: begin
				if (left > 0) left--;
				if (left == 0) st = ST_KEY;
			end
			ST_DATA: begin
				if (pos < 4) word |= 32'(b) << (8 * pos);
				pos++;
				if (left > 0) left--;
				if (left == 0 || eod) begin
					run_item();
					st = ST_KEY;
				end
			end
		endcase
		if (eod) begin
			ids = 0;
			foreach (rid_map[i]) ids += rid_map[i];
			r = '0;
			r.kind = KIND_SUMMARY;
			r.word_a = ((in_bits + 7) >> 3) + 1;
			r.word_b = ((out_bits + 7) >> 3) + 1;
			r.word_c = {1'b0, ((feat_bits + 7) >> 3) + 32'd1};
			r.page = first_pg;
			r.usage_value = first_use;
			r.distinct_ids = 9'(ids);
			post(r);
			clear_state();
		end
		if (rec_q.size() > first_idx) rec_q[rec_q.size() - 1].last = 1'b1;
	endfunction

	task automatic cmp(string name, logic [32:0] exp_v, logic [32:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		clear_state();
	end

	always @(posedge clk) begin
		rec_t e;
		if (arst_n) begin
			if (desc.valid && desc.ready) take_byte(desc.desc_byte, desc.end_of_desc);
			if (rec.valid && rec.ready) begin
				if (rec_q.size() == 0) begin
					$error("unexpected record: kind %0d", rec.kind);
					fail_count++;
				end else begin
					e = rec_q.pop_front();
					cmp("kind", e.kind, rec.kind);
					cmp("word_a", e.word_a, rec.word_a);
					cmp("word_b", e.word_b, rec.word_b);
					cmp("word_c", e.word_c, rec.word_c);
					cmp("var_flag", e.var_flag, rec.var_flag);
					cmp("page", e.page, rec.page);
					cmp("usage_value", e.usage_value, rec.usage_value);
					cmp("usage_count", e.usage_count, rec.usage_count);
					cmp("distinct_ids", e.distinct_ids, rec.distinct_ids);
					cmp("usages_truncated", e.usages_truncated, rec.usages_truncated);
					cmp("last", e.last, rec.last);
				end
			end
		end
	end
endmodule

FILE: sim/tb_hid_descriptor_item_parser_core.sv
// ----------------------------------------------------------------------------
// tb_hid_descriptor_item_parser_core
// Feeds the parser hand-built and random descriptors with random idling on
// both channels and a long record hold-off; the checker scores the records.
// ----------------------------------------------------------------------------
module tb_hid_descriptor_item_parser_core;
	timeunit 1ns;
	timeprecision 1ps;
	import hidp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_cnt;
	// set while idling is switched off on both sides
	logic no_idle;
	// set while the record side is held off for a long stretch
	logic hold_req;

	hidp_desc_if desc ();
	hidp_rec_if  rec ();

	hid_descriptor_item_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.desc   (desc),
		.rec    (rec)
	);

	hidp_parser_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (desc),
		.rec        (rec),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any hang ends the run as a failure
	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt >= CYCLE_LIMIT) begin
				$display("tb_hid_descriptor_item_parser_core NOT OK");
				$finish;
			end
		end
	end

	// record side: random stalls, none while no_idle, nothing while held off
	initial begin
		rec.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req)
				rec.ready <= 1'b0;
			else
				rec.ready <= no_idle || ($urandom_range(99) >= 27);
		end
	end

	// byte queue filled by the stimulus tasks, drained by the driver
	logic [8:0] byte_q [$];

	// offer one byte, holding it until it is taken
	task automatic send(logic [7:0] b, logic eod);
		desc.valid       <= 1'b1;
		desc.desc_byte   <= b;
		desc.end_of_desc <= eod;
		do @(posedge clk); while (!desc.ready);
	endtask

	task automatic drain_bytes();
		logic [8:0] x;
		while (byte_q.size() > 0) begin
			x = byte_q.pop_front();
			if (!no_idle) begin
				while ($urandom_range(99) < 27) begin
					desc.valid <= 1'b0;
					@(posedge clk);
				end
			end
			send(x[7:0], x[8]);
		end
		desc.valid <= 1'b0;
		@(posedge clk);
	endtask

	// short item: key tag plus 0,1,2 or 4 data bytes (size code 3 means 4)
	task automatic put_item(logic [7:0] tag, logic [1:0] sz, logic [31:0] v);
		int n;
		n = (sz == 2'd3) ? 4 : sz;
		byte_q.push_back({1'b0, tag | 8'(sz)});
		for (int i = 0; i < n; i++) byte_q.push_back({1'b0, v[8*i +: 8]});
	endtask

	task automatic put_end(logic [7:0] b);
		byte_q.push_back({1'b1, b});
	endtask

	function automatic logic [7:0] rand_tag();
		case ($urandom_range(12))
			0: return TAG_PAGE;
			1, 2: return TAG_USAGE;
			3: return TAG_RSIZE;
			4: return TAG_RCOUNT;
			5, 6: return TAG_INPUT;
			7: return TAG_OUTPUT;
			8: return TAG_FEATURE;
			9: return TAG_RID;
			10: return TAG_UMIN;
			11: return TAG_UMAX;
			default: return TAG_LMAX;
		endcase
	endfunction

	// one random descriptor: mostly well-formed items, some noise and long items
	task automatic put_random_desc();
		int          n_items;
		logic [31:0] v;
		logic [31:0] base;
		n_items = $urandom_range(12, 2);
		for (int k = 0; k < n_items; k++) begin
			case ($urandom_range(9))
				0: begin
					// long item
					byte_q.push_back({1'b0, 8'hF0 | 8'($urandom_range(15))});
					v = $urandom_range(3);
					byte_q.push_back({1'b0, v[7:0]});
					byte_q.push_back({1'b0, 8'($urandom)});
					for (int i = 0; i < v; i++) byte_q.push_back({1'b0, 8'($urandom)});
				end
				1: put_item(8'($urandom) & TAG_MASK, 2'($urandom), $urandom);
				2: begin
					// usage range, sometimes reversed or wide
					base = $urandom_range(40);
					put_item(TAG_UMIN, 2'd1, base);
					v = ($urandom_range(5) == 0) ? base - 1 - $urandom_range(1) :
						base + $urandom_range(36);
					put_item(TAG_UMAX, 2'd1, v);
					put_item(TAG_INPUT, 2'd1, 32'h2 | ($urandom & 32'h40));
				end
				default: begin
					v = ($urandom_range(3) == 0) ? $urandom : $urandom_range(300);
					put_item(rand_tag(), 2'($urandom), v);
				end
			endcase
		end
		// last byte: a key, sometimes cut-off data instead
		if ($urandom_range(2) == 0) begin
			byte_q.push_back({1'b0, rand_tag() | 8'd3});
			for (int i = $urandom_range(2); i > 0; i--) byte_q.push_back({1'b0, 8'($urandom)});
			put_end(8'($urandom));
		end else
			put_end(8'($urandom));
	endtask

	// wait for every record, then let any trailing item work finish
	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	initial begin
		desc.valid       <= 1'b0;
		desc.desc_byte   <= '0;
		desc.end_of_desc <= 1'b0;
		no_idle  = 1'b0;
		hold_req = 1'b0;
		arst_n   = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pages, first usage, 4-byte usage, extremes, null flag
		put_item(TAG_PAGE, 2'd2, 32'h0000_FFFF);
		put_item(TAG_USAGE, 2'd1, 32'h06);
		put_item(TAG_USAGE, 2'd3, 32'hABCD_1234);
		put_item(TAG_USAGE, 2'd2, 32'h0000_FFFF);
		put_item(TAG_RSIZE, 2'd3, 32'hFFFF_FFFF);
		put_item(TAG_RCOUNT, 2'd3, 32'hFFFF_FFFF);
		put_item(TAG_LMAX, 2'd3, 32'hFFFF_FFFF);
		put_item(TAG_INPUT, 2'd1, 32'h42);
		put_item(TAG_RID, 2'd1, 32'hFF);
		put_item(TAG_RID, 2'd1, 32'h00);
		put_item(TAG_OUTPUT, 2'd0, 0);
		put_item(TAG_FEATURE, 2'd1, 0);
		put_end(TAG_USAGE | 8'd3);
		drain_bytes();
		// ranges with maximum one below minimum add nothing, array input between
		put_item(TAG_USAGE, 2'd1, 32'h01);
		put_item(TAG_UMIN, 2'd1, 32'h10);
		put_item(TAG_UMAX, 2'd1, 32'h0F);
		put_item(TAG_INPUT, 2'd1, 32'h02);
		put_item(TAG_USAGE, 2'd1, 32'h05);
		put_item(TAG_INPUT, 2'd0, 0);
		put_item(TAG_UMIN, 2'd1, 32'h20);
		put_item(TAG_UMAX, 2'd1, 32'h1F);
		put_item(TAG_INPUT, 2'd1, 32'h02);
		byte_q.push_back({1'b0, 8'hFE});
		put_end(8'h00);
		drain_bytes();
		put_item(TAG_USAGE, 2'd3, 32'h0);
		byte_q.push_back({1'b0, TAG_USAGE | 8'd3});
		byte_q.push_back({1'b0, 8'h55});
		put_end(8'hAA);
		drain_bytes();
		put_end(8'hFF);
		drain_bytes();
		settle();

		// long hold-off on the record side while bytes keep coming
		fork
			begin
				hold_req = 1'b1;
				repeat (600) @(posedge clk);
				hold_req = 1'b0;
			end
			begin
				for (int k = 0; k < 3; k++) begin
					put_item(TAG_UMIN, 2'd1, 0);
					put_item(TAG_UMAX, 2'd1, 20);
					put_item(TAG_INPUT, 2'd1, 32'h02);
				end
				put_end(8'h00);
				drain_bytes();
			end
		join
		settle();

		// random descriptors; one stretch with no idling at all
		for (int d = 0; d < 6; d++) begin
			no_idle = (d >= 2 && d < 4);
			put_random_desc();
			drain_bytes();
		end
		no_idle = 1'b0;
		settle();

		if (fail_count == 0)
			$display("tb_hid_descriptor_item_parser_core OK");
		else
			$display("tb_hid_descriptor_item_parser_core NOT OK");
		$finish;
	end
endmodule
